>>> rtl/gsi_pkg.sv
// Shared widths and item types for the gain schedule interpolator.
package gsi_pkg;

   localparam int unsigned SPEED_W     = 32;
   localparam int unsigned BREAK_W     = 31;
   localparam int unsigned GAIN_W      = 32;
   localparam int unsigned PAIR_W      = 64;
   localparam int unsigned SEG_W       = 2;
   localparam int unsigned QUOT_W      = 32;
   localparam int unsigned PROD_W      = BREAK_W + GAIN_W;
   localparam int unsigned QUEUE_DEPTH = 2;

   // classified item handed from the front to the back
   typedef struct packed {
      logic [BREAK_W-1:0] mag;
      logic [BREAK_W-1:0] lo;
      logic [BREAK_W-1:0] hi;
      logic [GAIN_W-1:0]  kp_lo;
      logic [GAIN_W-1:0]  kp_hi;
      logic [GAIN_W-1:0]  ki_lo;
      logic [GAIN_W-1:0]  ki_hi;
      logic [SEG_W-1:0]   seg;
      logic               at_end;
   } gsi_job_type;

   // per-item data that rides alongside the divider
   typedef struct packed {
      logic [BREAK_W-1:0] den;
      logic [GAIN_W-1:0]  kp_lo;
      logic [GAIN_W-1:0]  ki_lo;
      logic               kp_neg;
      logic               ki_neg;
      logic               bypass;
      logic [SEG_W-1:0]   seg;
   } gsi_side_type;

endpackage

>>> rtl/gsi_front.sv
// Front end: breakpoint and gain registers, magnitude and segment search.
module gsi_front #(
   parameter int unsigned NUM_BREAKPOINTS = 3
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic [gsi_pkg::SPEED_W-1:0]                  req_measured_speed,
   input  logic                                         csr_wr_en,
   input  logic [$clog2(2*NUM_BREAKPOINTS)-1:0]         csr_index,
   input  logic [gsi_pkg::PAIR_W-1:0]                   csr_wdata,
   input  logic                                         q_full,
   output logic                                         push_valid,
   output gsi_pkg::gsi_job_type                         push_job
);
   import gsi_pkg::*;

   localparam int unsigned IDX_W = $clog2(2*NUM_BREAKPOINTS);
   localparam int unsigned SIDX_W = $clog2(NUM_BREAKPOINTS+1);

   logic [BREAK_W-1:0] brk_ff [NUM_BREAKPOINTS];
   logic [GAIN_W-1:0]  kp_ff  [NUM_BREAKPOINTS];
   logic [GAIN_W-1:0]  ki_ff  [NUM_BREAKPOINTS];

   logic               v1_ff, v1_in;
   logic [BREAK_W-1:0] mag1_ff, mag1_in;
   logic               take;
   logic [SPEED_W-1:0] neg_speed;
   logic [SIDX_W-1:0]  s;
   gsi_job_type        job;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
            brk_ff[i] <= '0;
            kp_ff[i]  <= '0;
            ki_ff[i]  <= '0;
         end
      end else if (csr_wr_en) begin
         for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
            if (csr_index == IDX_W'(i)) begin
               brk_ff[i] <= csr_wdata[BREAK_W-1:0];
            end
            if (csr_index == IDX_W'(NUM_BREAKPOINTS + i)) begin
               kp_ff[i] <= csr_wdata[PAIR_W-1:GAIN_W];
               ki_ff[i] <= csr_wdata[GAIN_W-1:0];
            end
         end
      end
   end

   // most negative code saturates to the largest magnitude
   always_comb begin
      take = start && !q_full;
      neg_speed = '0 - req_measured_speed;
      if (!req_measured_speed[SPEED_W-1]) begin
         mag1_in = req_measured_speed[BREAK_W-1:0];
      end else if (neg_speed[SPEED_W-1]) begin
         mag1_in = '1;
      end else begin
         mag1_in = neg_speed[BREAK_W-1:0];
      end
      if (take) begin
         v1_in = 1'b1;
      end else if (v1_ff && !q_full) begin
         v1_in = 1'b0;
      end else begin
         v1_in = v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mag1_ff <= mag1_in;
      end
   end

   // first breakpoint not below the magnitude
   always_comb begin
      s = SIDX_W'(NUM_BREAKPOINTS);
      for (int i = NUM_BREAKPOINTS - 1; i >= 0; i--) begin
         if (mag1_ff <= brk_ff[i]) begin
            s = SIDX_W'(i);
         end
      end
      job.mag    = mag1_ff;
      job.seg    = s[SEG_W-1:0];
      job.at_end = (s == '0) || (s == SIDX_W'(NUM_BREAKPOINTS));
      job.lo     = brk_ff[0];
      job.hi     = brk_ff[0];
      job.kp_lo  = kp_ff[0];
      job.kp_hi  = kp_ff[0];
      job.ki_lo  = ki_ff[0];
      job.ki_hi  = ki_ff[0];
      if (s == SIDX_W'(NUM_BREAKPOINTS)) begin
         job.kp_lo = kp_ff[NUM_BREAKPOINTS-1];
         job.ki_lo = ki_ff[NUM_BREAKPOINTS-1];
      end
      for (int i = 1; i < NUM_BREAKPOINTS; i++) begin
         if (s == SIDX_W'(i)) begin
            job.lo    = brk_ff[i-1];
            job.hi    = brk_ff[i];
            job.kp_lo = kp_ff[i-1];
            job.kp_hi = kp_ff[i];
            job.ki_lo = ki_ff[i-1];
            job.ki_hi = ki_ff[i];
         end
      end
   end

   assign push_valid = v1_ff && !q_full;
   assign push_job   = job;

endmodule

>>> rtl/gsi_queue.sv
// Short item queue between the front end and the interpolation pipeline.
module gsi_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  gsi_pkg::gsi_job_type push_job,
   output logic                 pop_valid,
   output gsi_pkg::gsi_job_type pop_job,
   output logic                 full
);
   import gsi_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   gsi_job_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   // the back end never stalls, so anything held is taken at once
   always_comb begin
      pop       = (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_valid = pop;
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

>>> rtl/gsi_back.sv
// Back end: segment offsets, gain step products and pipelined restoring divide.
module gsi_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   input  gsi_pkg::gsi_job_type          pop_job,
   output logic                          rsp_valid,
   output logic [gsi_pkg::GAIN_W-1:0]    rsp_prop_gain,
   output logic [gsi_pkg::GAIN_W-1:0]    rsp_integ_gain,
   output logic [gsi_pkg::SEG_W-1:0]     rsp_segment
);
   import gsi_pkg::*;

   function automatic logic [BREAK_W+QUOT_W-1:0] div_step(
      input logic [BREAK_W-1:0] rem,
      input logic [QUOT_W-1:0]  sh,
      input logic [BREAK_W-1:0] den
   );
      logic [BREAK_W:0] t;
      logic [BREAK_W:0] d;
      t = {rem, sh[QUOT_W-1]};
      d = t - {1'b0, den};
      if (t >= {1'b0, den}) begin
         return {d[BREAK_W-1:0], sh[QUOT_W-2:0], 1'b1};
      end
      return {t[BREAK_W-1:0], sh[QUOT_W-2:0], 1'b0};
   endfunction

   // offset stage
   logic               b0_valid_ff;
   logic [BREAK_W-1:0] b0_num_ff, b0_num_in;
   logic [GAIN_W-1:0]  b0_kp_diff_ff, b0_kp_diff_in;
   logic [GAIN_W-1:0]  b0_ki_diff_ff, b0_ki_diff_in;
   gsi_side_type       b0_side_ff, b0_side_in;

   // divider stages, index 0 is the product stage
   logic               dv_valid_ff [QUOT_W+1];
   logic [BREAK_W-1:0] kp_rem_ff   [QUOT_W+1];
   logic [QUOT_W-1:0]  kp_sh_ff    [QUOT_W+1];
   logic [BREAK_W-1:0] ki_rem_ff   [QUOT_W+1];
   logic [QUOT_W-1:0]  ki_sh_ff    [QUOT_W+1];
   gsi_side_type       dv_side_ff  [QUOT_W+1];

   logic [PROD_W-1:0]  kp_prod_in, ki_prod_in;

   logic               out_valid_ff;
   logic [GAIN_W-1:0]  out_kp_ff, out_kp_in;
   logic [GAIN_W-1:0]  out_ki_ff, out_ki_in;
   logic [SEG_W-1:0]   out_seg_ff;

   always_comb begin
      b0_num_in         = pop_job.mag - pop_job.lo;
      b0_side_in.den    = pop_job.hi - pop_job.lo;
      b0_side_in.kp_lo  = pop_job.kp_lo;
      b0_side_in.ki_lo  = pop_job.ki_lo;
      b0_side_in.kp_neg = pop_job.kp_hi < pop_job.kp_lo;
      b0_side_in.ki_neg = pop_job.ki_hi < pop_job.ki_lo;
      b0_side_in.bypass = pop_job.at_end || (pop_job.hi <= pop_job.lo) ||
                          (pop_job.mag <= pop_job.lo);
      b0_side_in.seg    = pop_job.seg;
      b0_kp_diff_in     = b0_side_in.kp_neg ? pop_job.kp_lo - pop_job.kp_hi
                                            : pop_job.kp_hi - pop_job.kp_lo;
      b0_ki_diff_in     = b0_side_in.ki_neg ? pop_job.ki_lo - pop_job.ki_hi
                                            : pop_job.ki_hi - pop_job.ki_lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
      end else begin
         b0_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      b0_num_ff     <= b0_num_in;
      b0_kp_diff_ff <= b0_kp_diff_in;
      b0_ki_diff_ff <= b0_ki_diff_in;
      b0_side_ff    <= b0_side_in;
   end

   // product stage; its top bits stay below the divisor when interpolating
   assign kp_prod_in = PROD_W'(b0_num_ff) * PROD_W'(b0_kp_diff_ff);
   assign ki_prod_in = PROD_W'(b0_num_ff) * PROD_W'(b0_ki_diff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= b0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      kp_rem_ff[0]  <= kp_prod_in[PROD_W-1:QUOT_W];
      kp_sh_ff[0]   <= kp_prod_in[QUOT_W-1:0];
      ki_rem_ff[0]  <= ki_prod_in[PROD_W-1:QUOT_W];
      ki_sh_ff[0]   <= ki_prod_in[QUOT_W-1:0];
      dv_side_ff[0] <= b0_side_ff;
   end

   // one quotient bit per stage
   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      logic [BREAK_W+QUOT_W-1:0] kp_step_in, ki_step_in;

      always_comb begin
         kp_step_in = div_step(kp_rem_ff[k], kp_sh_ff[k], dv_side_ff[k].den);
         ki_step_in = div_step(ki_rem_ff[k], ki_sh_ff[k], dv_side_ff[k].den);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         kp_rem_ff[k+1]  <= kp_step_in[BREAK_W+QUOT_W-1:QUOT_W];
         kp_sh_ff[k+1]   <= kp_step_in[QUOT_W-1:0];
         ki_rem_ff[k+1]  <= ki_step_in[BREAK_W+QUOT_W-1:QUOT_W];
         ki_sh_ff[k+1]   <= ki_step_in[QUOT_W-1:0];
         dv_side_ff[k+1] <= dv_side_ff[k];
      end
   end

   // apply the increment towards the upper gain, or pass the lower gain on bypass
   always_comb begin
      if (dv_side_ff[QUOT_W].bypass) begin
         out_kp_in = dv_side_ff[QUOT_W].kp_lo;
         out_ki_in = dv_side_ff[QUOT_W].ki_lo;
      end else begin
         out_kp_in = dv_side_ff[QUOT_W].kp_neg
                   ? dv_side_ff[QUOT_W].kp_lo - kp_sh_ff[QUOT_W]
                   : dv_side_ff[QUOT_W].kp_lo + kp_sh_ff[QUOT_W];
         out_ki_in = dv_side_ff[QUOT_W].ki_neg
                   ? dv_side_ff[QUOT_W].ki_lo - ki_sh_ff[QUOT_W]
                   : dv_side_ff[QUOT_W].ki_lo + ki_sh_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      out_kp_ff  <= out_kp_in;
      out_ki_ff  <= out_ki_in;
      out_seg_ff <= dv_side_ff[QUOT_W].seg;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_prop_gain  = out_kp_ff;
   assign rsp_integ_gain = out_ki_ff;
   assign rsp_segment    = out_seg_ff;

endmodule

>>> rtl/gain_schedule_interpolator_unit.sv
// Top level of the piecewise-linear speed gain scheduler.
// A speed sample is taken on any cycle with start high and busy low, one per
// cycle without gaps. Its Kp/Ki pair appears on the rsp_ ports for a single
// cycle with rsp_valid high, after the sample register, the queue, the offset
// and product stages, the divider and the output register; the delay is set
// mostly by the 32-stage pipelined divider that forms the interpolation step,
// one quotient bit per stage. Results
// come out in input order and cannot be held off, so they must be captured
// on the strobe. Breakpoints and gain pairs must be written through the csr_
// port only while no sample is in flight; the block does not enforce this.
// Indexes beyond the register list are ignored.
module gain_schedule_interpolator_unit #(
   parameter int unsigned NUM_BREAKPOINTS = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [gsi_pkg::SPEED_W-1:0]           req_measured_speed,
   output logic                                  rsp_valid,
   output logic [gsi_pkg::GAIN_W-1:0]            rsp_prop_gain,
   output logic [gsi_pkg::GAIN_W-1:0]            rsp_integ_gain,
   output logic [gsi_pkg::SEG_W-1:0]             rsp_segment,
   input  logic                                  csr_wr_en,
   input  logic [$clog2(2*NUM_BREAKPOINTS)-1:0]  csr_index,
   input  logic [gsi_pkg::PAIR_W-1:0]            csr_wdata
);
   import gsi_pkg::*;

   logic        push_valid;
   gsi_job_type push_job;
   logic        pop_valid;
   gsi_job_type pop_job;
   logic        q_full;

   gsi_front #(
      .NUM_BREAKPOINTS(NUM_BREAKPOINTS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_measured_speed (req_measured_speed),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_full             (q_full),
      .push_valid         (push_valid),
      .push_job           (push_job)
   );

   gsi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .full       (q_full)
   );

   gsi_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_job        (pop_job),
      .rsp_valid      (rsp_valid),
      .rsp_prop_gain  (rsp_prop_gain),
      .rsp_integ_gain (rsp_integ_gain),
      .rsp_segment    (rsp_segment)
   );

   assign busy = q_full;

endmodule

>>> tb/tb_gain_schedule_interpolator_unit.sv
// Self-checking testbench for the piecewise-linear speed gain scheduler.
`timescale 1ns / 1ps

module tb_gain_schedule_interpolator_unit;

   localparam int NUM_BREAKS  = 3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 40;

   typedef enum logic [2:0] {
      REG_BREAK0  = 3'd0,
      REG_BREAK1  = 3'd1,
      REG_BREAK2  = 3'd2,
      REG_PAIR0   = 3'd3,
      REG_PAIR1   = 3'd4,
      REG_PAIR2   = 3'd5,
      REG_UNUSED6 = 3'd6,
      REG_UNUSED7 = 3'd7
   } csr_reg_e;

   typedef struct packed {
      logic [gsi_pkg::GAIN_W-1:0] prop;
      logic [gsi_pkg::GAIN_W-1:0] integ;
      logic [gsi_pkg::SEG_W-1:0]  seg;
   } gain_result_t;

   class gain_ledger;
      logic [gsi_pkg::BREAK_W-1:0] brk[NUM_BREAKS];
      logic [gsi_pkg::GAIN_W-1:0]  kp_set[NUM_BREAKS];
      logic [gsi_pkg::GAIN_W-1:0]  ki_set[NUM_BREAKS];
      gain_result_t                pending_gains[$];
      int                          fail_count;

      function new();
         foreach (brk[i]) begin
            brk[i]    = '0;
            kp_set[i] = '0;
            ki_set[i] = '0;
         end
         fail_count = 0;
      endfunction

      function void set_register(csr_reg_e idx, logic [63:0] data);
         case (idx)
            REG_BREAK0, REG_BREAK1, REG_BREAK2: begin
               brk[idx - REG_BREAK0] = data[gsi_pkg::BREAK_W-1:0];
            end
            REG_PAIR0, REG_PAIR1, REG_PAIR2: begin
               kp_set[idx - REG_PAIR0] = data[63:32];
               ki_set[idx - REG_PAIR0] = data[31:0];
            end
            default: ;
         endcase
      endfunction

      function logic [31:0] blend(logic [30:0] x, logic [30:0] lo, logic [30:0] hi,
                                  logic [31:0] glo, logic [31:0] ghi);
         logic [63:0] span;
         logic [63:0] width;
         logic [63:0] step;
         logic [63:0] diff;
         if (hi <= lo || x <= lo)
            return glo;
         if (x > hi)
            x = hi;
         span  = x - lo;
         width = hi - lo;
         if (ghi >= glo) begin
            diff = ghi - glo;
            step = span * diff / width;
            return glo + step[31:0];
         end
         diff = glo - ghi;
         step = span * diff / width;
         return glo - step[31:0];
      endfunction

      function gain_result_t schedule_gains(logic [31:0] speed);
         logic [31:0]  neg;
         logic [30:0]  mag;
         int           s;
         gain_result_t r;
         if (speed[31]) begin
            neg = -speed;
            mag = neg[31] ? 31'h7FFF_FFFF : neg[30:0];
         end else begin
            mag = speed[30:0];
         end
         s = 0;
         while (s < NUM_BREAKS && mag > brk[s])
            s++;
         if (s == 0) begin
            r.prop  = kp_set[0];
            r.integ = ki_set[0];
         end else if (s == NUM_BREAKS) begin
            r.prop  = kp_set[NUM_BREAKS-1];
            r.integ = ki_set[NUM_BREAKS-1];
         end else begin
            r.prop  = blend(mag, brk[s-1], brk[s], kp_set[s-1], kp_set[s]);
            r.integ = blend(mag, brk[s-1], brk[s], ki_set[s-1], ki_set[s]);
         end
         r.seg = s[1:0];
         return r;
      endfunction

      function void note_speed(logic [31:0] speed);
         pending_gains.push_back(schedule_gains(speed));
      endfunction

      function int outstanding();
         return pending_gains.size();
      endfunction

      task report_mismatch(string msg);
         fail_count++;
         $display("%0t ns: mismatch: %s", $time, msg);
      endtask

      task check_gains(gain_result_t got);
         gain_result_t want;
         if (pending_gains.size() == 0) begin
            report_mismatch($sformatf("result with no item outstanding (kp %h ki %h seg %0d)",
                                      got.prop, got.integ, got.seg));
            return;
         end
         want = pending_gains.pop_front();
         if (got.prop !== want.prop)
            report_mismatch($sformatf("prop_gain %h, expected %h", got.prop, want.prop));
         if (got.integ !== want.integ)
            report_mismatch($sformatf("integ_gain %h, expected %h", got.integ, want.integ));
         if (got.seg !== want.seg)
            report_mismatch($sformatf("segment %0d, expected %0d", got.seg, want.seg));
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [gsi_pkg::SPEED_W-1:0]   req_measured_speed = '0;
   logic                          rsp_valid;
   logic [gsi_pkg::GAIN_W-1:0]    rsp_prop_gain;
   logic [gsi_pkg::GAIN_W-1:0]    rsp_integ_gain;
   logic [gsi_pkg::SEG_W-1:0]     rsp_segment;
   logic                          csr_wr_en = 1'b0;
   logic [2:0]                    csr_index = '0;
   logic [gsi_pkg::PAIR_W-1:0]    csr_wdata = '0;

   gain_ledger sb = new();
   int         cycle_count = 0;

   gain_schedule_interpolator_unit #(
      .NUM_BREAKPOINTS(NUM_BREAKS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_measured_speed (req_measured_speed),
      .rsp_valid          (rsp_valid),
      .rsp_prop_gain      (rsp_prop_gain),
      .rsp_integ_gain     (rsp_integ_gain),
      .rsp_segment        (rsp_segment),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_gain_schedule_interpolator_unit: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_gains('{prop: rsp_prop_gain, integ: rsp_integ_gain, seg: rsp_segment});
   end

   task automatic write_csr(csr_reg_e idx, logic [63:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // upper bits of a breakpoint write are noise and must be dropped
   function automatic logic [63:0] break_word(logic [30:0] b);
      return {$urandom, $urandom_range(0, 1) == 1, b};
   endfunction

   task automatic load_schedule(logic [30:0] b0, logic [30:0] b1, logic [30:0] b2,
                                logic [63:0] p0, logic [63:0] p1, logic [63:0] p2);
      write_csr(REG_BREAK0, break_word(b0));
      write_csr(REG_BREAK1, break_word(b1));
      write_csr(REG_BREAK2, break_word(b2));
      write_csr(REG_PAIR0, p0);
      write_csr(REG_PAIR1, p1);
      write_csr(REG_PAIR2, p2);
      write_csr(REG_UNUSED6, {$urandom, $urandom});
      write_csr(REG_UNUSED7, {$urandom, $urandom});
   endtask

   task automatic send_speed(logic [31:0] speed);
      @(negedge clock);
      start              <= 1'b1;
      req_measured_speed <= speed;
      do
         @(posedge clock);
      while (busy);
      sb.note_speed(speed);
   endtask

   task automatic idle_burst(int n);
      @(negedge clock);
      start              <= 1'b0;
      req_measured_speed <= $urandom;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_speed();
      logic [30:0] mag;
      logic [31:0] lo;
      logic [31:0] hi;
      int          k;
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         3, 4, 5: begin
            k   = $urandom_range(0, NUM_BREAKS - 1);
            mag = 31'(sb.brk[k] + $urandom_range(0, 4) - 2);
         end
         default: begin
            k  = $urandom_range(1, NUM_BREAKS - 1);
            lo = {1'b0, sb.brk[k-1]};
            hi = {1'b0, sb.brk[k]};
            if (hi > lo)
               mag = 31'(lo + ($urandom % (hi - lo + 1)));
            else
               mag = lo[30:0];
         end
      endcase
      return $urandom_range(0, 1) ? -{1'b0, mag} : {1'b0, mag};
   endfunction

   task automatic run_batch(int count, int gap_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < gap_pct)
            idle_burst($urandom_range(1, 19));
         send_speed(pick_speed());
      end
   endtask

   task automatic load_random_schedule();
      logic [30:0] b[NUM_BREAKS];
      logic [30:0] t;
      foreach (b[i]) begin
         if ($urandom_range(0, 1))
            b[i] = 31'($urandom);
         else
            b[i] = 31'($urandom_range(0, 32'h000F_FFFF));
      end
      if (b[0] > b[1]) begin t = b[0]; b[0] = b[1]; b[1] = t; end
      if (b[1] > b[2]) begin t = b[1]; b[1] = b[2]; b[2] = t; end
      if (b[0] > b[1]) begin t = b[0]; b[0] = b[1]; b[1] = t; end
      load_schedule(b[0], b[1], b[2], {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom});
   endtask

   initial begin
      logic [31:0] directed_speeds[] = '{
         32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h8000_0001, 32'h0001_0000, 32'h0001_0001, 32'hFFFF_0000, 32'h0001_8000,
         32'h0002_0000, 32'h0002_0001, 32'hFFFD_0000, 32'h0003_FFFF, 32'h0004_0000,
         32'h0004_0001, 32'hFFFB_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
      };
      int phases;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers still at their reset values
      send_speed(32'h0000_0000);
      send_speed(32'h1234_5678);
      drain_results();

      // rising Kp, falling Ki in the middle segment
      load_schedule(31'h0001_0000, 31'h0002_0000, 31'h0004_0000,
                    {32'h0001_0000, 32'h0005_0000}, {32'h0003_0000, 32'h0002_0000},
                    {32'hFFFF_FFFF, 32'h0000_0000});
      foreach (directed_speeds[i])
         send_speed(directed_speeds[i]);
      drain_results();

      // widest spans and gain swings
      load_schedule(31'h0000_0000, 31'h4000_0000, 31'h7FFF_FFFF,
                    '1, '0, '1);
      run_batch(60, $urandom_range(0, 40));
      drain_results();

      // breakpoints out of order
      load_schedule(31'h0005_0000, 31'h0001_0000, 31'h0003_0000,
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      run_batch(60, $urandom_range(0, 40));
      drain_results();

      // all breakpoints equal: zero-width segments
      begin
         logic [30:0] flat;
         flat = 31'($urandom_range(1, 32'h0010_0000));
         load_schedule(flat, flat, flat, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom});
      end
      run_batch(60, $urandom_range(0, 40));
      drain_results();

      // top breakpoints, all-ones data except an all-zero middle pair
      write_csr(REG_BREAK0, '1);
      write_csr(REG_BREAK1, '1);
      write_csr(REG_BREAK2, '1);
      write_csr(REG_PAIR0, '1);
      write_csr(REG_PAIR1, '0);
      write_csr(REG_PAIR2, '1);
      run_batch(60, 0);
      drain_results();

      phases = 8;
      for (int p = 0; p < phases; p++) begin
         load_random_schedule();
         run_batch(105, (p == phases - 1) ? 0 : $urandom_range(0, 45));
         drain_results();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.fail_count == 0)
         $display("tb_gain_schedule_interpolator_unit: clean");
      else
         $display("tb_gain_schedule_interpolator_unit: errors");
      $finish;
   end

endmodule

>>> sim.f
rtl/gsi_pkg.sv
rtl/gsi_front.sv
rtl/gsi_queue.sv
rtl/gsi_back.sv
rtl/gain_schedule_interpolator_unit.sv
tb/tb_gain_schedule_interpolator_unit.sv
